@@ sv/gle_pkg.sv @@
// Shared types, codes and fixed-point helpers for the glyph layout engine.
`default_nettype none

package gle_pkg;

	localparam int GLYPH_SLOTS_DEF = 128;
	localparam int SLOT_PORT_W     = 7;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_W           = 24;

	// command codes
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_CHAR  = 2'd1;
	localparam logic [1:0] CMD_RESET = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MARGIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_LINE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TEXEL_HEIGHT = 3'd4;

	localparam logic [15:0] NUL_CODE     = 16'h0000;
	localparam logic [15:0] NEWLINE_CODE = 16'h000A;
	localparam logic [23:0] SCALE_RST    = 24'h010000;
	localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MUL_B,
		ST_RND_B,
		ST_EMIT,
		ST_ADV
	} state_t;

	// one glyph slot as stored in the RAM
	typedef struct packed {
		logic [15:0]        advance;
		logic signed [15:0] bearing;
		logic [15:0]        tex_width;
		logic [15:0]        tex_y;
		logic [15:0]        tex_x;
		logic [15:0]        key;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Q.16 product to signed Q26.8, nearest with ties up: floor((p + 128) / 256)
	function automatic logic signed [33:0] round_q8(input logic signed [41:0] p);
		logic signed [41:0] t;
		t = p + 42'sd128;
		return t[41:8];
	endfunction

	function automatic logic signed [23:0] sat_q24(input logic signed [35:0] v);
		logic signed [23:0] r;
		if (v > 36'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -36'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ sv/gle_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ sv/glyph_layout_engine.sv @@
// Glyph layout engine top level: slot search, shared multiplier and cursor state.
`default_nettype none

// Channel  | valid     | stall     | word
// ---------+-----------+-----------+--------------------------------------------------
// in       | in_valid  | in_stall  | cmd, char_code, glyph_slot, tex_*, bearing, advance
// out      | out_valid | out_stall | quad_x, quad_y, quad_u/v/w/h, quad_number
// cfg      | cfg_we    | -         | cfg_index, cfg_data (no wait)
//
// Load, reset, newline, NUL and ignored words are taken in ST_IDLE without leaving it.
// A character word scans the slots one per cycle through the RAM read port:
// a miss ends after the last slot; a hit runs ST_MUL_B, ST_RND_B, ST_EMIT and ST_ADV.
// Reset initialises control state, valid marks, cursor and registers; slot data stays unknown.
// One finished quad waits in the output register; the next word is taken meanwhile,
// and a later quad waits in ST_EMIT until that register is free.

module glyph_layout_engine #(
	parameter int GLYPH_SLOTS = gle_pkg::GLYPH_SLOTS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input words
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     cmd,
	input  wire logic [15:0]                    char_code,
	input  wire logic [gle_pkg::SLOT_PORT_W-1:0] glyph_slot,
	input  wire logic [15:0]                    tex_x,
	input  wire logic [15:0]                    tex_y,
	input  wire logic [15:0]                    tex_width,
	input  wire logic signed [15:0]             bearing,
	input  wire logic [15:0]                    advance,
	// output words
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [23:0]                  quad_x,
	output logic signed [23:0]                  quad_y,
	output logic [15:0]                         quad_u,
	output logic [15:0]                         quad_v,
	output logic [15:0]                         quad_w,
	output logic [15:0]                         quad_h,
	output logic [15:0]                         quad_number,
	// register writes
	input  wire logic                           cfg_we,
	input  wire logic [gle_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gle_pkg::CFG_W-1:0]      cfg_data
);

	import gle_pkg::*;

	// the 7-bit slot field cannot reach past 128 slots
	localparam int DEPTH  = (GLYPH_SLOTS < (1 << SLOT_PORT_W)) ? GLYPH_SLOTS
	                                                           : (1 << SLOT_PORT_W);
	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

	// registers
	logic signed [23:0] left_margin_q;
	logic signed [23:0] top_line_q;
	logic [22:0]        line_height_q;
	logic [23:0]        scale_q;
	logic [15:0]        texel_height_q;

	// layout state
	state_t             state_q, state_nxt;
	logic signed [23:0] cursor_x_q;
	logic signed [23:0] cursor_y_q;
	logic               string_ended_q;
	logic [15:0]        quad_count_q;
	logic               valid_q [DEPTH];

	// search and datapath
	logic [SLOT_W-1:0]  addr_q;
	logic               pend_s1;
	logic               valid_s1;
	logic               last_s1;
	logic [15:0]        code_q;
	entry_t             hit_q;
	entry_t             rd_entry;
	entry_t             wr_entry;
	logic signed [41:0] prod_q;
	logic signed [33:0] off_q;
	logic               out_valid_q;

	logic               in_acc;
	logic               load_ok;
	logic               is_char;
	logic               start_search;
	logic               hit;
	logic               search_exit;
	logic               emit_go;
	logic               mul_sel_adv;
	logic signed [16:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [41:0] mul_p;

	assign in_acc  = in_valid && !in_stall;
	assign load_ok = (cmd == CMD_LOAD) && (32'(glyph_slot) < GLYPH_SLOTS);
	assign is_char = (cmd == CMD_CHAR) && !string_ended_q;
	assign start_search = in_acc && is_char && (char_code != NUL_CODE)
		&& (char_code != NEWLINE_CODE);

	assign hit         = pend_s1 && valid_s1 && (rd_entry.key == code_q);
	assign search_exit = hit || (pend_s1 && last_s1);

	assign wr_entry = '{advance: advance, bearing: bearing, tex_width: tex_width,
		tex_y: tex_y, tex_x: tex_x, key: char_code};

	gle_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH),
		.AW    (SLOT_W)
	) u_slots (
		.clk   (clk),
		.we    (in_acc && load_ok),
		.waddr (glyph_slot[SLOT_W-1:0]),
		.wdata (wr_entry),
		.raddr (addr_q),
		.rdata (rd_entry)
	);

	// shared multiplier: bearing first, then advance, both times scale
	assign mul_a = mul_sel_adv ? $signed({1'b0, hit_q.advance})
	                           : $signed({hit_q.bearing[15], hit_q.bearing});
	assign mul_b = $signed({1'b0, scale_q});
	assign mul_p = mul_a * mul_b;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start_search) begin
					state_nxt = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					state_nxt = ST_MUL_B;
				end else if (search_exit) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_MUL_B: state_nxt = ST_RND_B;
			ST_RND_B: state_nxt = ST_EMIT;
			ST_EMIT: begin
				if (emit_go) begin
					state_nxt = ST_ADV;
				end
			end
			ST_ADV:   state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall    = 1'b1;
		mul_sel_adv = 1'b0;
		emit_go     = 1'b0;
		case (state_q)
			ST_IDLE:  in_stall = 1'b0;
			ST_RND_B: mul_sel_adv = 1'b1;
			ST_EMIT:  emit_go = !out_valid_q || !out_stall;
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_margin_q  <= '0;
			top_line_q     <= '0;
			line_height_q  <= '0;
			scale_q        <= SCALE_RST;
			texel_height_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LEFT_MARGIN:  left_margin_q  <= cfg_data;
				CFG_TOP_LINE:     top_line_q     <= cfg_data;
				CFG_LINE_HEIGHT:  line_height_q  <= cfg_data[22:0];
				CFG_SCALE:        scale_q        <= cfg_data;
				CFG_TEXEL_HEIGHT: texel_height_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// valid marks, one flop per slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (in_acc && load_ok) begin
			valid_q[glyph_slot[SLOT_W-1:0]] <= 1'b1;
		end
	end

	// slot scan: address issued one cycle, tag compared the next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= (state_q == ST_SEARCH) && !search_exit;
			if (state_q != ST_SEARCH) begin
				addr_q <= '0;
			end else if (addr_q == LAST_SLOT) begin
				addr_q <= '0;
			end else begin
				addr_q <= addr_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		valid_s1 <= valid_q[addr_q];
		last_s1  <= (addr_q == LAST_SLOT);
		if (start_search) begin
			code_q <= char_code;
		end
		if (hit) begin
			hit_q <= rd_entry;
		end
		if (state_q == ST_MUL_B || state_q == ST_RND_B) begin
			prod_q <= mul_p;
		end
		if (state_q == ST_RND_B || emit_go) begin
			off_q <= round_q8(prod_q);
		end
	end

	// cursor, line and quad count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q     <= '0;
			cursor_y_q     <= '0;
			string_ended_q <= 1'b0;
			quad_count_q   <= '0;
		end else if (in_acc && cmd == CMD_RESET) begin
			cursor_x_q     <= left_margin_q;
			cursor_y_q     <= top_line_q;
			string_ended_q <= 1'b0;
			quad_count_q   <= '0;
		end else if (in_acc && is_char && char_code == NUL_CODE) begin
			string_ended_q <= 1'b1;
		end else if (in_acc && is_char && char_code == NEWLINE_CODE) begin
			cursor_x_q <= left_margin_q;
			cursor_y_q <= sat_q24(36'(cursor_y_q) + 36'(line_height_q));
		end else if (state_q == ST_ADV) begin
			cursor_x_q <= sat_q24(36'(cursor_x_q) + 36'(off_q));
			if (quad_count_q != COUNT_MAX) begin
				quad_count_q <= quad_count_q + 16'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			quad_x      <= sat_q24(36'(cursor_x_q) + 36'(off_q));
			quad_y      <= cursor_y_q;
			quad_u      <= hit_q.tex_x;
			quad_v      <= hit_q.tex_y;
			quad_w      <= hit_q.tex_width;
			quad_h      <= texel_height_q;
			quad_number <= quad_count_q;
		end
	end

	assign out_valid = out_valid_q;

	// an ended string never starts a search
	a_ended_no_search: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && cmd == CMD_CHAR && string_ended_q) |=> (state_q == ST_IDLE))
		else $error("search started after end of string");

	// compare stage only carries a slot while scanning
	a_pend_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == ST_SEARCH))
		else $error("scan compare outside search");

	// a held quad is never overwritten
	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && out_valid_q && out_stall) |=> (state_q == ST_EMIT))
		else $error("quad emitted over a waiting word");

	// quad count sticks at its maximum
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV && quad_count_q == COUNT_MAX) |=> (quad_count_q == COUNT_MAX))
		else $error("quad count wrapped");

endmodule

`default_nettype wire
